// ----- sv/imoc_pkg.sv -----
// Shared types, register map codes and helpers for the IMU motion and
// orientation classifier. Used by every module of the block.
`default_nettype none

package imoc_pkg;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_ENABLED     = 3'd0;
   localparam logic [2:0] REG_ORIENT_LIM  = 3'd1;
   localparam logic [2:0] REG_GYRO_LIM    = 3'd2;
   localparam logic [2:0] REG_ACCEL_VALID = 3'd3;
   localparam logic [2:0] REG_ACCEL_HIGH  = 3'd4;
   localparam logic [2:0] REG_ACCEL_LOW   = 3'd5;

   localparam logic [15:0] ORIENT_LIM_RST  = 16'd2663;
   localparam logic [31:0] GYRO_LIM_RST    = 32'd1638400;
   localparam logic [31:0] ACCEL_VALID_RST = 32'd8220836;
   localparam logic [31:0] ACCEL_HIGH_RST  = 32'd23360596;
   localparam logic [31:0] ACCEL_LOW_RST   = 32'd11281000;

   // Orientation codes
   localparam logic [2:0] ORIENT_UNKNOWN   = 3'd0;
   localparam logic [2:0] ORIENT_FACE_UP   = 3'd1;
   localparam logic [2:0] ORIENT_FACE_DOWN = 3'd2;
   localparam logic [2:0] ORIENT_RIGHT_UP  = 3'd3;
   localparam logic [2:0] ORIENT_LEFT_UP   = 3'd4;
   localparam logic [2:0] ORIENT_USB_UP    = 3'd5;
   localparam logic [2:0] ORIENT_USB_DOWN  = 3'd6;

   typedef struct packed {
      logic        enabled;
      logic [15:0] orient_abs_limit;
      logic [31:0] gyro_sq_limit;
      logic [31:0] accel_valid_sq_limit;
      logic [31:0] accel_high_sq_limit;
      logic [31:0] accel_low_sq_limit;
   } cfg_type;

   // Request after the squaring stage
   typedef struct packed {
      logic        read_ok;
      logic        all_zero;
      logic [2:0]  orientation;
      logic [31:0] ax_sq;
      logic [31:0] ay_sq;
      logic [31:0] az_sq;
      logic [31:0] gx_sq;
      logic [31:0] gy_sq;
      logic [31:0] gz_sq;
   } sq_item_type;

   function automatic logic [15:0] abs16(input logic signed [15:0] v);
      logic signed [15:0] neg;
      neg = -v;
      return v[15] ? 16'(neg) : 16'(v);
   endfunction

endpackage

`default_nettype wire

// ----- sv/imoc_csr.sv -----
// APB-style register file for the classifier thresholds and enable.
// Depends on imoc_pkg for the register map and cfg_type.
`default_nettype none

module imoc_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [imoc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [imoc_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [imoc_pkg::DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output imoc_pkg::cfg_type                cfg
);

   imoc_pkg::cfg_type cfg_ff;
   logic [2:0]        index;
   logic              wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled              <= 1'b0;
         cfg_ff.orient_abs_limit     <= imoc_pkg::ORIENT_LIM_RST;
         cfg_ff.gyro_sq_limit        <= imoc_pkg::GYRO_LIM_RST;
         cfg_ff.accel_valid_sq_limit <= imoc_pkg::ACCEL_VALID_RST;
         cfg_ff.accel_high_sq_limit  <= imoc_pkg::ACCEL_HIGH_RST;
         cfg_ff.accel_low_sq_limit   <= imoc_pkg::ACCEL_LOW_RST;
      end else if (wr_en) begin
         case (index)
            imoc_pkg::REG_ENABLED:     cfg_ff.enabled              <= csr_pwdata[0];
            imoc_pkg::REG_ORIENT_LIM:  cfg_ff.orient_abs_limit     <= csr_pwdata[15:0];
            imoc_pkg::REG_GYRO_LIM:    cfg_ff.gyro_sq_limit        <= csr_pwdata;
            imoc_pkg::REG_ACCEL_VALID: cfg_ff.accel_valid_sq_limit <= csr_pwdata;
            imoc_pkg::REG_ACCEL_HIGH:  cfg_ff.accel_high_sq_limit  <= csr_pwdata;
            imoc_pkg::REG_ACCEL_LOW:   cfg_ff.accel_low_sq_limit   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         imoc_pkg::REG_ENABLED:     csr_prdata = {31'd0, cfg_ff.enabled};
         imoc_pkg::REG_ORIENT_LIM:  csr_prdata = {16'd0, cfg_ff.orient_abs_limit};
         imoc_pkg::REG_GYRO_LIM:    csr_prdata = cfg_ff.gyro_sq_limit;
         imoc_pkg::REG_ACCEL_VALID: csr_prdata = cfg_ff.accel_valid_sq_limit;
         imoc_pkg::REG_ACCEL_HIGH:  csr_prdata = cfg_ff.accel_high_sq_limit;
         imoc_pkg::REG_ACCEL_LOW:   csr_prdata = cfg_ff.accel_low_sq_limit;
         default:                   csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/imoc_square.sv -----
// Squaring stage: per-axis magnitudes, six registered squares, the
// all-zero check and the orientation pick. Depends on imoc_pkg.
`default_nettype none

module imoc_square (
   input  wire logic               clock,
   input  wire logic               enable,
   input  wire logic               read_ok,
   input  wire logic signed [15:0] accel_x,
   input  wire logic signed [15:0] accel_y,
   input  wire logic signed [15:0] accel_z,
   input  wire logic signed [15:0] gyro_x,
   input  wire logic signed [15:0] gyro_y,
   input  wire logic signed [15:0] gyro_z,
   input  wire logic [15:0]        orient_abs_limit,
   output imoc_pkg::sq_item_type   item
);

   imoc_pkg::sq_item_type item_ff;
   imoc_pkg::sq_item_type item_in;
   logic [15:0] ax_abs, ay_abs, az_abs, gx_abs, gy_abs, gz_abs;
   logic [2:0]  orient;

   assign ax_abs = imoc_pkg::abs16(accel_x);
   assign ay_abs = imoc_pkg::abs16(accel_y);
   assign az_abs = imoc_pkg::abs16(accel_z);
   assign gx_abs = imoc_pkg::abs16(gyro_x);
   assign gy_abs = imoc_pkg::abs16(gyro_y);
   assign gz_abs = imoc_pkg::abs16(gyro_z);

   // z wins ties over x and y, x wins over y; zero counts as positive
   always_comb begin
      if (ax_abs < orient_abs_limit && ay_abs < orient_abs_limit &&
          az_abs < orient_abs_limit) begin
         orient = imoc_pkg::ORIENT_UNKNOWN;
      end else if (az_abs >= ax_abs && az_abs >= ay_abs) begin
         orient = accel_z[15] ? imoc_pkg::ORIENT_FACE_DOWN : imoc_pkg::ORIENT_FACE_UP;
      end else if (ax_abs >= ay_abs) begin
         orient = accel_x[15] ? imoc_pkg::ORIENT_LEFT_UP : imoc_pkg::ORIENT_RIGHT_UP;
      end else begin
         orient = accel_y[15] ? imoc_pkg::ORIENT_USB_DOWN : imoc_pkg::ORIENT_USB_UP;
      end
   end

   always_comb begin
      item_in.read_ok     = read_ok;
      item_in.all_zero    = (accel_x == 16'sd0) && (accel_y == 16'sd0) &&
                            (accel_z == 16'sd0) && (gyro_x == 16'sd0) &&
                            (gyro_y == 16'sd0) && (gyro_z == 16'sd0);
      item_in.orientation = orient;
      item_in.ax_sq       = 32'(ax_abs) * 32'(ax_abs);
      item_in.ay_sq       = 32'(ay_abs) * 32'(ay_abs);
      item_in.az_sq       = 32'(az_abs) * 32'(az_abs);
      item_in.gx_sq       = 32'(gx_abs) * 32'(gx_abs);
      item_in.gy_sq       = 32'(gy_abs) * 32'(gy_abs);
      item_in.gz_sq       = 32'(gz_abs) * 32'(gz_abs);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

`default_nettype wire

// ----- sv/imoc_state.sv -----
// Classification and state stage: sums the squares, applies the motion
// thresholds and updates the held results and counters. Depends on imoc_pkg.
`default_nettype none

module imoc_state (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire imoc_pkg::sq_item_type item,
   input  wire imoc_pkg::cfg_type     cfg,
   output logic                       accepted,
   output logic [2:0]                 orientation,
   output logic                       moving,
   output logic                       data_valid,
   output logic [31:0]                accel_sq_sum,
   output logic [31:0]                gyro_sq_sum,
   output logic [31:0]                sample_count,
   output logic [31:0]                zero_count,
   output logic [31:0]                fail_count
);

   logic        accepted_ff, accepted_in;
   logic [2:0]  orient_ff, orient_in;
   logic        moving_ff, moving_in;
   logic        valid_ff, valid_in;
   logic [31:0] accel_sq_ff, accel_sq_in;
   logic [31:0] gyro_sq_ff, gyro_sq_in;
   logic [31:0] samples_ff, samples_in;
   logic [31:0] zeros_ff, zeros_in;
   logic [31:0] fails_ff, fails_in;
   logic [31:0] accel_sum, gyro_sum;
   logic        plausible;

   // 3 * 2^30 is the largest sum, so 32 bits never overflow
   assign accel_sum = item.ax_sq + item.ay_sq + item.az_sq;
   assign gyro_sum  = item.gx_sq + item.gy_sq + item.gz_sq;
   assign plausible = accel_sum >= cfg.accel_valid_sq_limit;

   always_comb begin
      accepted_in = 1'b0;
      orient_in   = orient_ff;
      moving_in   = moving_ff;
      valid_in    = valid_ff;
      accel_sq_in = accel_sq_ff;
      gyro_sq_in  = gyro_sq_ff;
      samples_in  = samples_ff;
      zeros_in    = zeros_ff;
      fails_in    = fails_ff;
      if (cfg.enabled) begin
         if (!item.read_ok) begin
            fails_in = fails_ff + 32'd1;
            valid_in = 1'b0;
         end else begin
            accepted_in = 1'b1;
            samples_in  = samples_ff + 32'd1;
            valid_in    = !item.all_zero;
            if (item.all_zero) begin
               zeros_in = zeros_ff + 32'd1;
            end
            accel_sq_in = accel_sum;
            gyro_sq_in  = gyro_sum;
            moving_in   = (gyro_sum > cfg.gyro_sq_limit) ||
                          (plausible && (accel_sum >= cfg.accel_high_sq_limit ||
                                         accel_sum <= cfg.accel_low_sq_limit));
            orient_in   = item.orientation;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= 1'b0;
         orient_ff   <= imoc_pkg::ORIENT_UNKNOWN;
         moving_ff   <= 1'b0;
         valid_ff    <= 1'b0;
         accel_sq_ff <= '0;
         gyro_sq_ff  <= '0;
         samples_ff  <= '0;
         zeros_ff    <= '0;
         fails_ff    <= '0;
      end else if (load) begin
         accepted_ff <= accepted_in;
         orient_ff   <= orient_in;
         moving_ff   <= moving_in;
         valid_ff    <= valid_in;
         accel_sq_ff <= accel_sq_in;
         gyro_sq_ff  <= gyro_sq_in;
         samples_ff  <= samples_in;
         zeros_ff    <= zeros_in;
         fails_ff    <= fails_in;
      end
   end

   assign accepted     = accepted_ff;
   assign orientation  = orient_ff;
   assign moving       = moving_ff;
   assign data_valid   = valid_ff;
   assign accel_sq_sum = accel_sq_ff;
   assign gyro_sq_sum  = gyro_sq_ff;
   assign sample_count = samples_ff;
   assign zero_count   = zeros_ff;
   assign fail_count   = fails_ff;

   a_good_read_counts: assert property (@(posedge clock) disable iff (reset)
      (load && cfg.enabled && item.read_ok) |=>
         (accepted_ff && samples_ff == $past(samples_ff) + 32'd1))
      else $error("good read did not advance the sample count");

   a_failed_read: assert property (@(posedge clock) disable iff (reset)
      (load && cfg.enabled && !item.read_ok) |=>
         (!valid_ff && !accepted_ff && fails_ff == $past(fails_ff) + 32'd1
          && $stable(samples_ff)))
      else $error("failed read handled wrongly");

   a_disabled_holds: assert property (@(posedge clock) disable iff (reset)
      (load && !cfg.enabled) |=>
         (!accepted_ff && $stable(samples_ff) && $stable(fails_ff) && $stable(valid_ff)))
      else $error("disabled request changed state");

endmodule

`default_nettype wire

// ----- sv/imu_motion_orientation_classifier.sv -----
// Top level of the IMU motion and orientation classifier: input register,
// squaring stage, classification/result stage and the register file.
// Depends on imoc_pkg, imoc_csr, imoc_square and imoc_state.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------------
//   req      | req_valid/req_stall  | read_ok, accel_x/y/z, gyro_x/y/z
//   rsp      | rsp_valid/rsp_stall  | accepted, orientation, moving, data_valid, sums, counts
//   csr      | APB psel/penable     | six threshold/enable registers at 4*i
//
// One request per cycle sustained while rsp_stall stays low; each request's response
// passes through the input register, square register and result register in order.
// The result register doubles as the classifier state, so a stalled response
// holds the state too and the pipeline backs up one stage at a time.
// req_stall rises only when all three stages are full and rsp_stall is high.
// Synchronous active-high reset clears the stage valid bits, the state and the
// registers to their default thresholds; no clearing pass is needed.
`default_nettype none

module imu_motion_orientation_classifier (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_read_ok,
   input  wire logic signed [15:0]          req_accel_x,
   input  wire logic signed [15:0]          req_accel_y,
   input  wire logic signed [15:0]          req_accel_z,
   input  wire logic signed [15:0]          req_gyro_x,
   input  wire logic signed [15:0]          req_gyro_y,
   input  wire logic signed [15:0]          req_gyro_z,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_accepted,
   output logic [2:0]                       rsp_orientation,
   output logic                             rsp_moving,
   output logic                             rsp_data_valid,
   output logic [31:0]                      rsp_accel_sq_sum,
   output logic [31:0]                      rsp_gyro_sq_sum,
   output logic [31:0]                      rsp_sample_count,
   output logic [31:0]                      rsp_zero_count,
   output logic [31:0]                      rsp_fail_count,
   // configuration port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [imoc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [imoc_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [imoc_pkg::DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   imoc_pkg::cfg_type     cfg;
   imoc_pkg::sq_item_type sq_item;

   // Stage valid bits
   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Input register (payload only, no reset)
   logic               read_ok_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff, gz_ff;

   logic out_free, s1_free, s0_free, s1_move, s0_move, req_take;

   // Advance a stage when the one after it is empty or moving on
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || out_free;
   assign s0_move   = s0_valid_ff && s1_free;
   assign s0_free   = !s0_valid_ff || s1_free;
   assign req_stall = !s0_free;
   assign req_take  = req_valid && !req_stall;

   assign s0_valid_in  = req_take || (s0_valid_ff && !s1_free);
   assign s1_valid_in  = s0_move  || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move  || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_take) begin
         read_ok_ff <= req_read_ok;
         ax_ff      <= req_accel_x;
         ay_ff      <= req_accel_y;
         az_ff      <= req_accel_z;
         gx_ff      <= req_gyro_x;
         gy_ff      <= req_gyro_y;
         gz_ff      <= req_gyro_z;
      end
   end

   imoc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   imoc_square u_square (
      .clock            (clock),
      .enable           (s0_move),
      .read_ok          (read_ok_ff),
      .accel_x          (ax_ff),
      .accel_y          (ay_ff),
      .accel_z          (az_ff),
      .gyro_x           (gx_ff),
      .gyro_y           (gy_ff),
      .gyro_z           (gz_ff),
      .orient_abs_limit (cfg.orient_abs_limit),
      .item             (sq_item)
   );

   // State updates exactly when a request moves into the result register
   imoc_state u_state (
      .clock        (clock),
      .reset        (reset),
      .load         (s1_move),
      .item         (sq_item),
      .cfg          (cfg),
      .accepted     (rsp_accepted),
      .orientation  (rsp_orientation),
      .moving       (rsp_moving),
      .data_valid   (rsp_data_valid),
      .accel_sq_sum (rsp_accel_sq_sum),
      .gyro_sq_sum  (rsp_gyro_sq_sum),
      .sample_count (rsp_sample_count),
      .zero_count   (rsp_zero_count),
      .fail_count   (rsp_fail_count)
   );

   assign rsp_valid = rsp_valid_ff;

   a_take_fills_s0: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s0_valid_ff)
      else $error("accepted request not held in the input register");

   a_s1_move_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("state update without a response");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> (!s0_move && !s1_move))
      else $error("stage advanced into a full result register");

endmodule

`default_nettype wire

// ----- tb/tb_imu_motion_orientation_classifier.sv -----
// Testbench for the IMU motion and orientation classifier: directed and random readings,
// checked field by field against a cycle-free predictor of the classifier state.
// Depends on imoc_pkg and imu_motion_orientation_classifier.
`timescale 1ns / 100ps

module tb_imu_motion_orientation_classifier;

   // One classifier response as the block reports it
   typedef struct {
      logic        accepted;
      logic [2:0]  orientation;
      logic        moving;
      logic        data_valid;
      logic [31:0] accel_sq_sum;
      logic [31:0] gyro_sq_sum;
      logic [31:0] sample_count;
      logic [31:0] zero_count;
      logic [31:0] fail_count;
   } imu_status_type;

   // ---------------------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic                 req_read_ok = 1'b0;
   logic signed [15:0]   req_accel_x = '0;
   logic signed [15:0]   req_accel_y = '0;
   logic signed [15:0]   req_accel_z = '0;
   logic signed [15:0]   req_gyro_x  = '0;
   logic signed [15:0]   req_gyro_y  = '0;
   logic signed [15:0]   req_gyro_z  = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_accepted;
   logic [2:0]           rsp_orientation;
   logic                 rsp_moving;
   logic                 rsp_data_valid;
   logic [31:0]          rsp_accel_sq_sum;
   logic [31:0]          rsp_gyro_sq_sum;
   logic [31:0]          rsp_sample_count;
   logic [31:0]          rsp_zero_count;
   logic [31:0]          rsp_fail_count;

   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [imoc_pkg::ADDR_W-1:0]   csr_paddr   = '0;
   logic [imoc_pkg::DATA_W-1:0]   csr_pwdata  = '0;
   logic [imoc_pkg::DATA_W-1:0]   csr_prdata;
   logic                          csr_pready;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   imu_motion_orientation_classifier u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_read_ok      (req_read_ok),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_gyro_x       (req_gyro_x),
      .req_gyro_y       (req_gyro_y),
      .req_gyro_z       (req_gyro_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_orientation  (rsp_orientation),
      .rsp_moving       (rsp_moving),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_accel_sq_sum (rsp_accel_sq_sum),
      .rsp_gyro_sq_sum  (rsp_gyro_sq_sum),
      .rsp_sample_count (rsp_sample_count),
      .rsp_zero_count   (rsp_zero_count),
      .rsp_fail_count   (rsp_fail_count),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // ---------------------------------------------------------------------------------
   // Predictor state: a private copy of the thresholds and of the classifier registers
   // ---------------------------------------------------------------------------------
   imoc_pkg::cfg_type csr_model = '{
      enabled:              1'b0,
      orient_abs_limit:     imoc_pkg::ORIENT_LIM_RST,
      gyro_sq_limit:        imoc_pkg::GYRO_LIM_RST,
      accel_valid_sq_limit: imoc_pkg::ACCEL_VALID_RST,
      accel_high_sq_limit:  imoc_pkg::ACCEL_HIGH_RST,
      accel_low_sq_limit:   imoc_pkg::ACCEL_LOW_RST
   };

   logic [2:0]  orient_state   = imoc_pkg::ORIENT_UNKNOWN;
   logic        moving_state   = 1'b0;
   logic        valid_state    = 1'b0;
   logic [31:0] accel_sq_state = '0;
   logic [31:0] gyro_sq_state  = '0;
   logic [31:0] sample_total   = '0;
   logic [31:0] zero_total     = '0;
   logic [31:0] fail_total     = '0;

   imu_status_type expected_status_q[$];
   int             mismatch_count = 0;

   // Idling controls shared by the sender and the response stall process
   bit sender_gaps_on  = 1'b1;
   bit stall_bursts_on = 1'b1;
   bit hold_requested  = 1'b0;
   int hold_left       = 0;
   int stall_left      = 0;

   function automatic logic [31:0] magnitude(input logic signed [15:0] v);
      return (v < 0) ? 32'(-int'(v)) : 32'(int'(v));
   endfunction

   // |a|^2 + |b|^2 + |c|^2; at most 3 * 2^30, so 32 bits never overflow
   function automatic logic [31:0] square_sum(input logic signed [15:0] a, b, c);
      logic [31:0] ma, mb, mc;
      ma = magnitude(a);
      mb = magnitude(b);
      mc = magnitude(c);
      return ma * ma + mb * mb + mc * mc;
   endfunction

   // Advance the predicted classifier state by one reading and report the response
   function automatic imu_status_type classify_reading(input logic ok,
                                                       input logic signed [15:0] ax, ay, az,
                                                       input logic signed [15:0] gx, gy, gz);
      imu_status_type r;
      logic [31:0]    mx, my, mz, lim;
      logic           all_zero, plausible;
      r.accepted = 1'b0;
      if (csr_model.enabled) begin
         if (!ok) begin
            // failed read: count it, drop the valid flag, hold everything else
            fail_total  = fail_total + 1;
            valid_state = 1'b0;
         end else begin
            all_zero = ({ax, ay, az, gx, gy, gz} == '0);
            r.accepted   = 1'b1;
            sample_total = sample_total + 1;
            valid_state  = !all_zero;
            if (all_zero) begin
               zero_total = zero_total + 1;
            end
            accel_sq_state = square_sum(ax, ay, az);
            gyro_sq_state  = square_sum(gx, gy, gz);
            plausible    = (accel_sq_state >= csr_model.accel_valid_sq_limit);
            moving_state = (gyro_sq_state > csr_model.gyro_sq_limit) ||
                           (plausible && (accel_sq_state >= csr_model.accel_high_sq_limit ||
                                          accel_sq_state <= csr_model.accel_low_sq_limit));
            // dominant axis: z wins ties, then x; a zero sign counts as positive
            mx  = magnitude(ax);
            my  = magnitude(ay);
            mz  = magnitude(az);
            lim = 32'(csr_model.orient_abs_limit);
            if (mx < lim && my < lim && mz < lim) begin
               orient_state = imoc_pkg::ORIENT_UNKNOWN;
            end else if (mz >= mx && mz >= my) begin
               orient_state = az[15] ? imoc_pkg::ORIENT_FACE_DOWN
                                     : imoc_pkg::ORIENT_FACE_UP;
            end else if (mx >= my) begin
               orient_state = ax[15] ? imoc_pkg::ORIENT_LEFT_UP
                                     : imoc_pkg::ORIENT_RIGHT_UP;
            end else begin
               orient_state = ay[15] ? imoc_pkg::ORIENT_USB_DOWN
                                     : imoc_pkg::ORIENT_USB_UP;
            end
         end
      end
      r.orientation  = orient_state;
      r.moving       = moving_state;
      r.data_valid   = valid_state;
      r.accel_sq_sum = accel_sq_state;
      r.gyro_sq_sum  = gyro_sq_state;
      r.sample_count = sample_total;
      r.zero_count   = zero_total;
      r.fail_count   = fail_total;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Offer one reading, hold it until taken, then maybe drop valid for a short gap.
   // Called right after a rising edge; returns right after one.
   task automatic send_reading(input logic ok,
                               input logic signed [15:0] ax, ay, az, gx, gy, gz);
      req_valid   <= 1'b1;
      req_read_ok <= ok;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_gyro_x  <= gx;
      req_gyro_y  <= gy;
      req_gyro_z  <= gz;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_status_q.push_back(classify_reading(ok, ax, ay, az, gx, gy, gz));
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every outstanding response, then let the pipeline settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // One APB write: setup cycle, access cycle, then a return to idle with psel low so psel
   // is never lowered and raised again in the same step
   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= imoc_pkg::ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      case (index)
         imoc_pkg::REG_ENABLED:     csr_model.enabled              = value[0];
         imoc_pkg::REG_ORIENT_LIM:  csr_model.orient_abs_limit     = value[15:0];
         imoc_pkg::REG_GYRO_LIM:    csr_model.gyro_sq_limit        = value;
         imoc_pkg::REG_ACCEL_VALID: csr_model.accel_valid_sq_limit = value;
         imoc_pkg::REG_ACCEL_HIGH:  csr_model.accel_high_sq_limit  = value;
         imoc_pkg::REG_ACCEL_LOW:   csr_model.accel_low_sq_limit   = value;
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Reprogram every register, only once the block has gone idle
   task automatic program_setting(input logic en, input logic [15:0] orient,
                                  input logic [31:0] gyro, valid_lim, high_lim, low_lim);
      wait_drained();
      write_register(imoc_pkg::REG_ENABLED, 32'(en));
      write_register(imoc_pkg::REG_ORIENT_LIM, 32'(orient));
      write_register(imoc_pkg::REG_GYRO_LIM, gyro);
      write_register(imoc_pkg::REG_ACCEL_VALID, valid_lim);
      write_register(imoc_pkg::REG_ACCEL_HIGH, high_lim);
      write_register(imoc_pkg::REG_ACCEL_LOW, low_lim);
   endtask

   task automatic program_defaults(input logic en);
      program_setting(en, imoc_pkg::ORIENT_LIM_RST, imoc_pkg::GYRO_LIM_RST,
                      imoc_pkg::ACCEL_VALID_RST, imoc_pkg::ACCEL_HIGH_RST,
                      imoc_pkg::ACCEL_LOW_RST);
   endtask

   // Signed value spread evenly over -span..span
   function automatic logic signed [15:0] jitter(input int span);
      return 16'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Mostly plausible readings near rest on one axis, plus failed reads, all-zero
   // readings and full-range noise
   task automatic send_random_reading();
      int                 kind;
      int                 axis;
      int                 level;
      logic               ok;
      logic signed [15:0] a[3];
      logic signed [15:0] g[3];
      kind = $urandom_range(0, 99);
      ok   = (kind >= 8);
      for (int i = 0; i < 3; i++) begin
         a[i] = 16'($urandom());
         g[i] = 16'($urandom());
      end
      if (kind >= 8 && kind < 12) begin
         for (int i = 0; i < 3; i++) begin
            a[i] = '0;
            g[i] = '0;
         end
      end else if (kind >= 12 && kind < 65) begin
         axis = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) begin
            a[i] = jitter(800);
            g[i] = jitter(2000);
         end
         level   = 4096 + int'(jitter(1500));
         a[axis] = 16'($urandom_range(0, 1) ? level : -level);
      end
      send_reading(ok, a[0], a[1], a[2], g[0], g[1], g[2]);
   endtask

   task automatic send_random_batch(input int count);
      repeat (count) send_random_reading();
      wait_drained();
   endtask

   // ---------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------

   // Random short stall bursts, plus one long hold on request
   always @(posedge clock) begin
      if (hold_requested) begin
         hold_left      = 60;
         hold_requested = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left  = hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left  = stall_left - 1;
      end else if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left  = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [31:0] expected_value,
                              input logic [31:0] actual_value);
      if (actual_value !== expected_value) begin
         $error("%s: expected %0d, got %0d", name, expected_value, actual_value);
         mismatch_count++;
      end
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      imu_status_type exp_s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status_q.size() == 0) begin
            $error("response with no request pending");
            mismatch_count++;
         end else begin
            exp_s = expected_status_q.pop_front();
            check_field("accepted", 32'(exp_s.accepted), 32'(rsp_accepted));
            check_field("orientation", 32'(exp_s.orientation), 32'(rsp_orientation));
            check_field("moving", 32'(exp_s.moving), 32'(rsp_moving));
            check_field("data_valid", 32'(exp_s.data_valid), 32'(rsp_data_valid));
            check_field("accel_sq_sum", exp_s.accel_sq_sum, rsp_accel_sq_sum);
            check_field("gyro_sq_sum", exp_s.gyro_sq_sum, rsp_gyro_sq_sum);
            check_field("sample_count", exp_s.sample_count, rsp_sample_count);
            check_field("zero_count", exp_s.zero_count, rsp_zero_count);
            check_field("fail_count", exp_s.fail_count, rsp_fail_count);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Straight out of reset the block is disabled: readings report the cleared state
   task automatic test_reset_state();
      send_reading(1'b1, 16'sd100, -16'sd200, 16'sd4096, 16'sd5, 16'sd6, 16'sd7);
      send_reading(1'b0, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6);
      wait_drained();
   endtask

   // Every orientation, ties, extremes of the counts, failed and all-zero reads
   task automatic test_directed_readings();
      program_defaults(1'b1);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b0, 16'sd1234, 16'sd4096, -16'sd77, 16'sd9, 16'sd9, 16'sd9);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      // ties: z beats x and y, x beats y
      send_reading(1'b1, 16'sd3000, 16'sd3000, 16'sd3000, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, -16'sd3000, -16'sd3000, 16'sd100, 16'sd0, 16'sd0, 16'sd0);
      // extremes of every count
      send_reading(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_reading(1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      // rotation, slightly light, and implausibly small accel
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd4096, 16'sd2000, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd3300, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd2000, 16'sd0, 16'sd0, 16'sd0);
      wait_drained();
   endtask

   // Readings exactly at and next to every threshold
   task automatic test_threshold_edges();
      program_setting(1'b1, 16'd3000, 32'd1_000_000, 32'd4_000_000,
                      32'd25_000_000, 32'd9_000_000);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd1999, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd2000, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd2999, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd3000, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd3001, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd4999, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd5000, 16'sd0, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd3500, 16'sd1000, 16'sd0, 16'sd0);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd3500, 16'sd0, -16'sd1001, 16'sd0);
      // zero limit: a zero accel vector still resolves, zero sign counted positive
      program_setting(1'b1, 16'd0, imoc_pkg::GYRO_LIM_RST, imoc_pkg::ACCEL_VALID_RST,
                      imoc_pkg::ACCEL_HIGH_RST, imoc_pkg::ACCEL_LOW_RST);
      send_reading(1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd5);
      wait_drained();
   endtask

   // Disabled: good and failed reads both leave the state alone
   task automatic test_disabled_hold();
      program_defaults(1'b0);
      send_reading(1'b1, 16'sd4096, 16'sd0, 16'sd0, 16'sd3000, 16'sd0, 16'sd0);
      send_reading(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      wait_drained();
   endtask

   // Hold the response side off for a long stretch while readings keep coming,
   // so the pipeline fills and stalls its input
   task automatic test_back_pressure();
      program_defaults(1'b1);
      sender_gaps_on = 1'b0;
      hold_requested = 1'b1;
      repeat (24) send_random_reading();
      wait_drained();
      sender_gaps_on = 1'b1;
   endtask

   // Random readings under a series of settings, the extremes among them
   task automatic test_random_settings();
      program_defaults(1'b1);
      send_random_batch(100);
      program_setting(1'b1, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_random_batch(60);
      program_setting(1'b1, 16'h8000, 32'hC000_0000, 32'hC000_0000,
                      32'hC000_0000, 32'hC000_0000);
      send_random_batch(60);
      program_setting(1'b1, 16'($urandom_range(0, 32768)), $urandom_range(0, 4_000_000),
                      $urandom_range(0, 12_000_000), $urandom_range(12_000_000, 40_000_000),
                      $urandom_range(4_000_000, 20_000_000));
      send_random_batch(80);
      program_setting(1'b1, 16'($urandom_range(0, 32768)), $urandom_range(0, 32'hC000_0000),
                      $urandom_range(0, 32'hC000_0000), $urandom_range(0, 32'hC000_0000),
                      $urandom_range(0, 32'hC000_0000));
      send_random_batch(80);
      program_setting(1'b0, 16'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
      send_random_batch(30);
   endtask

   // Closing stretch at full rate, no idling on either side
   task automatic test_steady_stream();
      program_defaults(1'b1);
      sender_gaps_on  = 1'b0;
      stall_bursts_on = 1'b0;
      send_random_batch(120);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_readings();
      test_threshold_edges();
      test_disabled_hold();
      test_back_pressure();
      test_random_settings();
      test_steady_stream();
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
